@@ rtl/core/rbq_pkg.sv @@
// Shared constants, codes and controller/datapath interface types for the ring byte queue.
package rbq_pkg;

	// Storage geometry and field widths
	localparam int unsigned DEPTH     = 1024;
	localparam int unsigned PTR_W     = $clog2(DEPTH);
	localparam int unsigned CNT_W     = 11;
	localparam int unsigned OFS_W     = 10;
	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned MAX_BURST = 64;
	localparam int unsigned BURST_W   = $clog2(MAX_BURST + 1);

	// Capacity register
	localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(1024);
	localparam logic [CNT_W-1:0] CAP_MIN   = CNT_W'(2);
	localparam logic             REG_CAPACITY = 1'b0;

	// Command codes
	localparam logic [2:0] CMD_PUSH  = 3'd0;
	localparam logic [2:0] CMD_POP   = 3'd1;
	localparam logic [2:0] CMD_PEEK  = 3'd2;
	localparam logic [2:0] CMD_DROP  = 3'd3;
	localparam logic [2:0] CMD_CLEAR = 3'd4;

	// Result status codes
	localparam logic [2:0] STAT_OK     = 3'd0;
	localparam logic [2:0] STAT_FULL   = 3'd1;
	localparam logic [2:0] STAT_NOROOM = 3'd2;
	localparam logic [2:0] STAT_EMPTY  = 3'd3;
	localparam logic [2:0] STAT_SHORT  = 3'd4;

	// Controller states
	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_READ,
		S_EMIT
	} state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic take;
		logic single;
		logic start_burst;
		logic emit;
	} ctl_t;

	// Status from datapath to controller
	typedef struct packed {
		logic out_free;
		logic multi;
		logic last_byte;
		logic fill_over;
	} stat_t;

endpackage

@@ rtl/core/ring_byte_queue_peek_drop_unit.sv @@
// Top level of the ring byte queue with push bursts, pop, peek, drop and clear.
//
// Circular byte queue in a 1024-entry byte memory, with the capacity in use set by the
// capacity register (clamped to 2..1024; writing it empties the queue). Push, drop, clear,
// unknown commands and the error or zero-count forms of pop and peek give one result:
// the controller takes the transfer in S_IDLE, then decides and loads the result register
// in S_EXEC. A pop or peek that returns n bytes (n at most 64) starts its burst in S_EXEC;
// each byte is then a read of the memory's single registered read port in S_READ followed
// by a load of the result register in S_EMIT. The result register lets the next item be
// taken while the last result still waits for its transfer. There is no clearing pass after reset.
module ring_byte_queue_peek_drop_unit (
	input  logic        clk,
	input  logic        arst_n,
	// Input items
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // data_byte[7:0], count[18:8], offset[28:19], zero[31:29]
	input  logic [3:0]  s_tuser,  // cmd[2:0], burst_start[3]
	// Result items
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // data_out[7:0], amount[18:8], level[29:19], zero[31:30]
	output logic [2:0]  m_tuser,  // status[2:0]
	output logic        m_tlast,
	// Configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	rbq_pkg::ctl_t              ctl;
	rbq_pkg::stat_t             stat;
	logic                       cfg_we;
	logic [rbq_pkg::CNT_W-1:0]  cap_value;
	logic                       reg_hit;

	// Decode the register port
	assign pready  = 1'b1;
	assign reg_hit = (paddr[2] == rbq_pkg::REG_CAPACITY) && (paddr[1:0] == 2'b00);
	assign cfg_we  = psel && penable && pwrite && pready && (paddr[2] == rbq_pkg::REG_CAPACITY);
	assign prdata  = reg_hit ? 32'(cap_value) : '0;

	rbq_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.stat    (stat),
		.ctl     (ctl)
	);

	rbq_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.stat     (stat),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.cfg_we   (cfg_we),
		.cfg_wdata(pwdata[rbq_pkg::CNT_W-1:0]),
		.cap_value(cap_value),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

`ifndef SYNTHESIS
	// Fill count never passes the capacity in use
	a_fill_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		!stat.fill_over)
		else $error("fill count exceeds capacity");

	// One item at a time: intake closes right after a transfer
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input taken while an item is in progress");

	// A result is loaded only into a free output register
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.single || ctl.emit) |-> stat.out_free)
		else $error("result register overwritten before transfer");
`endif

endmodule

@@ rtl/core/rbq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module rbq_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write one entry, read one entry into the output register
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/core/rbq_ctrl.sv @@
// Controller state machine: sequences item intake, single results and byte bursts.
module rbq_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	input  rbq_pkg::stat_t stat,
	output rbq_pkg::ctl_t  ctl
);

	rbq_pkg::state_t state_q;
	rbq_pkg::state_t state_d;

	// Hold the state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rbq_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Advance the state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rbq_pkg::S_IDLE: begin
				if (s_tvalid) begin
					state_d = rbq_pkg::S_EXEC;
				end
			end
			rbq_pkg::S_EXEC: begin
				priority if (stat.multi) begin
					state_d = rbq_pkg::S_READ;
				end else if (stat.out_free) begin
					state_d = rbq_pkg::S_IDLE;
				end else begin
					state_d = state_q;
				end
			end
			rbq_pkg::S_READ: begin
				state_d = rbq_pkg::S_EMIT;
			end
			rbq_pkg::S_EMIT: begin
				if (stat.out_free) begin
					state_d = stat.last_byte ? rbq_pkg::S_IDLE : rbq_pkg::S_READ;
				end
			end
			default: begin
				state_d = rbq_pkg::S_IDLE;
			end
		endcase
	end

	// Drive datapath commands
	always_comb begin
		s_tready        = (state_q == rbq_pkg::S_IDLE);
		ctl.take        = (state_q == rbq_pkg::S_IDLE) && s_tvalid;
		ctl.single      = (state_q == rbq_pkg::S_EXEC) && !stat.multi && stat.out_free;
		ctl.start_burst = (state_q == rbq_pkg::S_EXEC) && stat.multi;
		ctl.emit        = (state_q == rbq_pkg::S_EMIT) && stat.out_free;
	end

endmodule

@@ rtl/core/rbq_dp.sv @@
// Datapath: queue pointers, fill count, byte memory, item registers and result register.
module rbq_dp (
	input  logic                      clk,
	input  logic                      arst_n,
	input  rbq_pkg::ctl_t             ctl,
	output rbq_pkg::stat_t            stat,
	input  logic [31:0]               s_tdata,
	input  logic [3:0]                s_tuser,
	input  logic                      cfg_we,
	input  logic [rbq_pkg::CNT_W-1:0] cfg_wdata,
	output logic [rbq_pkg::CNT_W-1:0] cap_value,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [31:0]               m_tdata,
	output logic [2:0]                m_tuser,
	output logic                      m_tlast
);

	localparam int unsigned CW = rbq_pkg::CNT_W;
	localparam int unsigned PW = rbq_pkg::PTR_W;
	localparam int unsigned BW = rbq_pkg::BURST_W;

	// Queue state
	logic [CW-1:0] cap_q;
	logic [PW-1:0] rp_q;
	logic [PW-1:0] wp_q;
	logic [CW-1:0] fill_q;
	logic          refused_q;

	// Latched item
	logic [2:0]                  cmd_q;
	logic [rbq_pkg::BYTE_W-1:0]  byte_q;
	logic                        start_q;
	logic [CW-1:0]               count_q;
	logic [rbq_pkg::OFS_W-1:0]   offset_q;

	// Burst walk
	logic [PW-1:0] ptr_q;
	logic [BW-1:0] remain_q;
	logic [BW-1:0] n_q;
	logic          pop_q;

	// Result register
	logic                       o_valid_q;
	logic [rbq_pkg::BYTE_W-1:0] o_data_q;
	logic [2:0]                 o_status_q;
	logic [CW-1:0]              o_amount_q;
	logic [CW-1:0]              o_level_q;
	logic                       o_last_q;

	// Combinational terms
	logic [CW-1:0]              cap_eff;
	logic                       full;
	logic                       empty;
	logic [CW-1:0]              room;
	logic [2:0]                 push_status;
	logic                       push_ok;
	logic [CW-1:0]              wp_inc;
	logic [PW-1:0]              wp_next;
	logic [CW-1:0]              avail_n;
	logic [BW-1:0]              pop_n;
	logic [BW-1:0]              peek_n;
	logic [BW-1:0]              burst_n;
	logic [CW:0]                peek_end;
	logic                       peek_short;
	logic [CW-1:0]              peek_sum;
	logic [PW-1:0]              peek_pos;
	logic [CW-1:0]              drop_sum;
	logic [PW-1:0]              drop_rp;
	logic [CW-1:0]              ptr_inc;
	logic [PW-1:0]              ptr_next;
	logic                       last_byte;
	logic [2:0]                 r_status;
	logic [CW-1:0]              r_amount;
	logic [CW-1:0]              r_level;
	logic                       ram_we;
	logic [rbq_pkg::BYTE_W-1:0] ram_rdata;

	// Clamp the capacity register to the usable range
	always_comb begin
		priority if (cap_q < rbq_pkg::CAP_MIN) begin
			cap_eff = rbq_pkg::CAP_MIN;
		end else if (cap_q > CW'(rbq_pkg::DEPTH)) begin
			cap_eff = CW'(rbq_pkg::DEPTH);
		end else begin
			cap_eff = cap_q;
		end
	end

	assign full  = (fill_q >= cap_eff);
	assign empty = (fill_q == '0);
	assign room  = cap_eff - fill_q;

	// Decide the fate of a push byte
	always_comb begin
		push_status = rbq_pkg::STAT_OK;
		priority if (start_q) begin
			priority if (full) begin
				push_status = rbq_pkg::STAT_FULL;
			end else if (count_q > room) begin
				push_status = rbq_pkg::STAT_NOROOM;
			end else begin
				push_status = rbq_pkg::STAT_OK;
			end
		end else if (refused_q) begin
			push_status = full ? rbq_pkg::STAT_FULL : rbq_pkg::STAT_NOROOM;
		end else if (full) begin
			push_status = rbq_pkg::STAT_FULL;
		end else begin
			push_status = rbq_pkg::STAT_OK;
		end
	end

	assign push_ok = (push_status == rbq_pkg::STAT_OK);
	assign wp_inc  = CW'(wp_q) + CW'(1);
	assign wp_next = (wp_inc == cap_eff) ? '0 : wp_inc[PW-1:0];

	// Clamp pop and drop to the fill level, bursts to the per-item limit
	assign avail_n = (count_q < fill_q) ? count_q : fill_q;
	assign pop_n   = (avail_n > CW'(rbq_pkg::MAX_BURST)) ? BW'(rbq_pkg::MAX_BURST)
		: avail_n[BW-1:0];
	assign peek_n  = (count_q > CW'(rbq_pkg::MAX_BURST)) ? BW'(rbq_pkg::MAX_BURST)
		: count_q[BW-1:0];
	assign burst_n = (cmd_q == rbq_pkg::CMD_POP) ? pop_n : peek_n;

	// Peek window check and start position, wrapped at the capacity
	assign peek_end   = (CW+1)'(offset_q) + (CW+1)'(count_q);
	assign peek_short = (peek_end > (CW+1)'(fill_q));
	assign peek_sum   = CW'(rp_q) + CW'(offset_q);
	assign peek_pos   = (peek_sum >= cap_eff) ? PW'(peek_sum - cap_eff) : peek_sum[PW-1:0];

	// Read pointer after a drop
	assign drop_sum = CW'(rp_q) + avail_n;
	assign drop_rp  = (drop_sum >= cap_eff) ? PW'(drop_sum - cap_eff) : drop_sum[PW-1:0];

	// Burst walk pointer
	assign ptr_inc   = CW'(ptr_q) + CW'(1);
	assign ptr_next  = (ptr_inc == cap_eff) ? '0 : ptr_inc[PW-1:0];
	assign last_byte = (remain_q == BW'(1));

	// Build a single-result answer
	always_comb begin
		r_status = rbq_pkg::STAT_OK;
		r_amount = '0;
		r_level  = fill_q;
		unique case (cmd_q)
			rbq_pkg::CMD_PUSH: begin
				r_status = push_status;
				r_level  = fill_q + CW'(push_ok);
			end
			rbq_pkg::CMD_POP: begin
				if (empty) begin
					r_status = rbq_pkg::STAT_EMPTY;
				end
			end
			rbq_pkg::CMD_PEEK: begin
				priority if (empty) begin
					r_status = rbq_pkg::STAT_EMPTY;
				end else if (peek_short) begin
					r_status = rbq_pkg::STAT_SHORT;
				end else begin
					r_status = rbq_pkg::STAT_OK;
				end
			end
			rbq_pkg::CMD_DROP: begin
				r_amount = avail_n;
				r_level  = fill_q - avail_n;
			end
			rbq_pkg::CMD_CLEAR: begin
				r_level = '0;
			end
			default: begin
				r_level = fill_q;
			end
		endcase
	end

	// Status toward the controller
	always_comb begin
		stat.out_free  = !o_valid_q || m_tready;
		stat.multi     = !empty && (((cmd_q == rbq_pkg::CMD_POP) && (pop_n != '0))
			|| ((cmd_q == rbq_pkg::CMD_PEEK) && !peek_short && (count_q != '0)));
		stat.last_byte = last_byte;
		stat.fill_over = (fill_q > cap_eff);
	end

	// Update queue state: configuration, single results, end of a pop burst
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q     <= rbq_pkg::CAP_RESET;
			rp_q      <= '0;
			wp_q      <= '0;
			fill_q    <= '0;
			refused_q <= 1'b0;
		end else if (cfg_we) begin
			cap_q     <= cfg_wdata;
			rp_q      <= '0;
			wp_q      <= '0;
			fill_q    <= '0;
			refused_q <= 1'b0;
		end else if (ctl.single) begin
			unique case (cmd_q)
				rbq_pkg::CMD_PUSH: begin
					if (start_q) begin
						refused_q <= !push_ok;
					end
					if (push_ok) begin
						wp_q   <= wp_next;
						fill_q <= fill_q + CW'(1);
					end
				end
				rbq_pkg::CMD_DROP: begin
					rp_q   <= drop_rp;
					fill_q <= fill_q - avail_n;
				end
				rbq_pkg::CMD_CLEAR: begin
					rp_q      <= '0;
					wp_q      <= '0;
					fill_q    <= '0;
					refused_q <= 1'b0;
				end
				default: begin
					fill_q <= fill_q;
				end
			endcase
		end else if (ctl.emit && last_byte && pop_q) begin
			rp_q   <= ptr_next;
			fill_q <= fill_q - CW'(n_q);
		end
	end

	// Latch the item and walk the burst
	always_ff @(posedge clk) begin
		if (ctl.take) begin
			cmd_q    <= s_tuser[2:0];
			start_q  <= s_tuser[3];
			byte_q   <= s_tdata[7:0];
			count_q  <= s_tdata[18:8];
			offset_q <= s_tdata[28:19];
		end
		if (ctl.start_burst) begin
			ptr_q    <= (cmd_q == rbq_pkg::CMD_POP) ? rp_q : peek_pos;
			remain_q <= burst_n;
			n_q      <= burst_n;
			pop_q    <= (cmd_q == rbq_pkg::CMD_POP);
		end else if (ctl.emit) begin
			ptr_q    <= ptr_next;
			remain_q <= remain_q - BW'(1);
		end
	end

	// Hold a result until its transfer completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_valid_q <= 1'b0;
		end else if (ctl.single || ctl.emit) begin
			o_valid_q <= 1'b1;
		end else if (m_tready) begin
			o_valid_q <= 1'b0;
		end
	end

	// Load the result payload
	always_ff @(posedge clk) begin
		if (ctl.single) begin
			o_data_q   <= '0;
			o_status_q <= r_status;
			o_amount_q <= r_amount;
			o_level_q  <= r_level;
			o_last_q   <= 1'b1;
		end else if (ctl.emit) begin
			o_data_q   <= ram_rdata;
			o_status_q <= rbq_pkg::STAT_OK;
			o_amount_q <= pop_q ? CW'(n_q) : '0;
			o_level_q  <= pop_q ? (fill_q - CW'(n_q)) : fill_q;
			o_last_q   <= last_byte;
		end
	end

	assign ram_we = ctl.single && (cmd_q == rbq_pkg::CMD_PUSH) && push_ok;

	// Byte store
	rbq_ram #(
		.WIDTH(rbq_pkg::BYTE_W),
		.DEPTH(rbq_pkg::DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(wp_q),
		.wdata(byte_q),
		.raddr(ptr_q),
		.rdata(ram_rdata)
	);

	assign cap_value = cap_q;
	assign m_tvalid  = o_valid_q;
	assign m_tdata   = {2'b00, o_level_q, o_amount_q, o_data_q};
	assign m_tuser   = o_status_q;
	assign m_tlast   = o_last_q;

endmodule
